// ===== rtl/core/sorted_key_port_table_top_macros.svh =====
// Assertion macros for the sorted key port table
`ifndef SORTED_KEY_PORT_TABLE_TOP_MACROS_SVH
`define SORTED_KEY_PORT_TABLE_TOP_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define SKPT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SKPT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/skpt_pkg.sv =====
// Shared constants and types of the sorted key port table
package skpt_pkg;

   localparam int CAPACITY = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int KEY_W    = 64;
   localparam int PORT_W   = 16;

   localparam logic [1:0] REQ_LOOKUP = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_DUMP   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DUMP
   } state_type;

   typedef struct packed {
      logic cmp_en;
      logic ins_en;
      logic rot_en;
   } cell_ctrl_type;

endpackage

// ===== rtl/core/skpt_cell.sv =====
// One table entry: compare against the request key, insert-shift and dump rotation
module skpt_cell (
   input  logic                            clock,
   input  skpt_pkg::cell_ctrl_type         ctrl,
   input  logic                            in_use,
   input  logic [skpt_pkg::KEY_W-1:0]      cmp_key,
   input  logic [skpt_pkg::KEY_W-1:0]      new_key,
   input  logic [skpt_pkg::PORT_W-1:0]     new_port,
   input  logic                            prev_lt,
   input  logic [skpt_pkg::KEY_W-1:0]      prev_key,
   input  logic [skpt_pkg::PORT_W-1:0]     prev_port,
   input  logic [skpt_pkg::KEY_W-1:0]      rot_key,
   input  logic [skpt_pkg::PORT_W-1:0]     rot_port,
   output logic [skpt_pkg::KEY_W-1:0]      key,
   output logic [skpt_pkg::PORT_W-1:0]     port,
   output logic                            lt,
   output logic                            hit
);
   import skpt_pkg::*;

   logic [KEY_W-1:0]  key_ff, key_in;
   logic [PORT_W-1:0] port_ff, port_in;
   logic              lt_ff, eq_ff;

   always_comb begin
      key_in  = key_ff;
      port_in = port_ff;
      if (ctrl.ins_en && !lt_ff) begin
         if (prev_lt) begin
            key_in  = new_key;
            port_in = new_port;
         end else begin
            key_in  = prev_key;
            port_in = prev_port;
         end
      end else if (ctrl.rot_en) begin
         key_in  = rot_key;
         port_in = rot_port;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      port_ff <= port_in;
      if (ctrl.cmp_en) begin
         lt_ff <= in_use && (key_ff < cmp_key);
         eq_ff <= in_use && (key_ff == cmp_key);
      end
   end

   assign key  = key_ff;
   assign port = port_ff;
   assign lt   = lt_ff;
   assign hit  = eq_ff;

endmodule

// ===== rtl/core/sorted_key_port_table_top.sv =====
// Sorted key port table: chain of entry cells with request sequencer and output register
// A request word is taken only while the table is idle. Lookup and insert pass through
// the accept cycle, in which every cell compares its key with the request key, and the
// execute state, which answers the lookup once the output register is free or shifts
// the cells for an insert that is not dropped. A dump enters the dump state, where the
// cells rotate within the occupied range, one entry reaching the output register per
// cycle while the result side does not stall; the table is back in order when the last
// word leaves. The output register lets the next request in while a result word waits.
module sorted_key_port_table_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_type,
   input  logic [skpt_pkg::KEY_W-1:0]      req_key,
   input  logic [skpt_pkg::PORT_W-1:0]     req_port,
   input  logic                            req_port_ok,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_found,
   output logic [skpt_pkg::KEY_W-1:0]      rsp_entry_key,
   output logic [skpt_pkg::PORT_W-1:0]     rsp_entry_port,
   output logic                            rsp_last
);
   import skpt_pkg::*;

`include "sorted_key_port_table_top_macros.svh"

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  dump_idx_ff, dump_idx_in;

   logic [1:0]        req_type_ff;
   logic [KEY_W-1:0]  req_key_ff;
   logic [PORT_W-1:0] req_port_ff;
   logic              req_port_ok_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff;
   logic [KEY_W-1:0]  rsp_key_ff;
   logic [PORT_W-1:0] rsp_port_ff;
   logic              rsp_last_ff;

   cell_ctrl_type     ctrl;
   logic              accept, out_free, drop, dump_last;
   logic              load_lookup, load_dump;

   logic [KEY_W-1:0]    cell_key  [CAPACITY];
   logic [PORT_W-1:0]   cell_port [CAPACITY];
   logic [CAPACITY-1:0] cell_lt, hit_vec, in_use;
   logic [PORT_W-1:0]   hit_port;

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign drop      = (req_key_ff == '0) || !req_port_ok_ff
                      || (count_ff == CNT_W'(CAPACITY)) || (|hit_vec);
   assign dump_last = ({{(CNT_W - IDX_W){1'b0}}, dump_idx_ff} == count_ff - CNT_W'(1));

   // entry cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam int NXT = (i + 1 < CAPACITY) ? i + 1 : 0;
      logic              wrap;
      logic              p_lt;
      logic [KEY_W-1:0]  p_key, r_key;
      logic [PORT_W-1:0] p_port, r_port;

      assign in_use[i] = CNT_W'(i) < count_ff;
      assign wrap      = (count_ff == CNT_W'(i + 1));
      assign r_key     = wrap ? cell_key[0]  : cell_key[NXT];
      assign r_port    = wrap ? cell_port[0] : cell_port[NXT];

      if (i == 0) begin : g_head
         assign p_lt   = 1'b1;
         assign p_key  = '0;
         assign p_port = '0;
      end else begin : g_body
         assign p_lt   = cell_lt[i-1];
         assign p_key  = cell_key[i-1];
         assign p_port = cell_port[i-1];
      end

      skpt_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .in_use    (in_use[i]),
         .cmp_key   (req_key),
         .new_key   (req_key_ff),
         .new_port  (req_port_ff),
         .prev_lt   (p_lt),
         .prev_key  (p_key),
         .prev_port (p_port),
         .rot_key   (r_key),
         .rot_port  (r_port),
         .key       (cell_key[i]),
         .port      (cell_port[i]),
         .lt        (cell_lt[i]),
         .hit       (hit_vec[i])
      );
   end

   always_comb begin
      hit_port = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_port = hit_port | (cell_port[i] & {PORT_W{hit_vec[i]}});
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            priority if (req_type_ff == REQ_LOOKUP) begin
               if (out_free) state_in = ST_IDLE;
            end else if (req_type_ff == REQ_DUMP && count_ff != '0) begin
               state_in = ST_DUMP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DUMP: begin
            if (out_free && dump_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready   = 1'b0;
      ctrl        = '0;
      load_lookup = 1'b0;
      load_dump   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            ctrl.cmp_en = req_valid;
         end
         ST_EXEC: begin
            ctrl.ins_en = (req_type_ff == REQ_INSERT) && !drop;
            load_lookup = (req_type_ff == REQ_LOOKUP) && out_free;
         end
         ST_DUMP: begin
            ctrl.rot_en = out_free;
            load_dump   = out_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins_en) count_in = count_ff + CNT_W'(1);
      dump_idx_in = dump_idx_ff;
      if (state_ff == ST_EXEC) begin
         dump_idx_in = '0;
      end else if (load_dump) begin
         dump_idx_in = dump_idx_ff + IDX_W'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (load_lookup || load_dump) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_type_ff    <= req_type;
         req_key_ff     <= req_key;
         req_port_ff    <= req_port;
         req_port_ok_ff <= req_port_ok;
      end
      if (load_lookup) begin
         rsp_found_ff <= |hit_vec;
         rsp_key_ff   <= req_key_ff;
         rsp_port_ff  <= hit_port;
         rsp_last_ff  <= 1'b1;
      end else if (load_dump) begin
         rsp_found_ff <= 1'b1;
         rsp_key_ff   <= cell_key[0];
         rsp_port_ff  <= cell_port[0];
         rsp_last_ff  <= dump_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_entry_key  = rsp_key_ff;
   assign rsp_entry_port = rsp_port_ff;
   assign rsp_last       = rsp_last_ff;

   `SKPT_ASSERT_IMP(a_count_range, 1'b1, count_ff <= CNT_W'(CAPACITY), "entry count overflow")
   `SKPT_ASSERT_IMP(a_single_hit, state_ff == ST_EXEC, $onehot0(hit_vec), "key held by two cells")
   `SKPT_ASSERT_NEXT(a_insert_count, ctrl.ins_en, count_ff == $past(count_ff) + CNT_W'(1), "insert lost count")
   `SKPT_ASSERT_IMP(a_dump_range, state_ff == ST_DUMP, {{(CNT_W - IDX_W){1'b0}}, dump_idx_ff} < count_ff, "dump index past table end")

endmodule
